[design/text_scroll_position_controller_assert.svh]
// assertion macros for the text scroll position controller
`ifndef TEXT_SCROLL_POSITION_CONTROLLER_ASSERT_SVH
`define TEXT_SCROLL_POSITION_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scroll controller assertion failed");

// next-cycle implication, checked out of reset
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scroll controller assertion failed");

`endif

[design/tsp_pkg.sv]
// types, codes and constants shared by the scroll position controller
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int POS_W = 14;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_STOPPED    = 3'd1,
        MODE_WRAP       = 3'd2,
        MODE_WRAP_LEFT  = 3'd3,
        MODE_BOUNCE_FWD = 3'd4,
        MODE_BOUNCE_REV = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_MODE     = 3'd0,
        REG_FRAMES_PER_STEP = 3'd1,
        REG_TEXT_WIDTH      = 3'd2,
        REG_VISIBLE_WIDTH   = 3'd3,
        REG_LEFT_OFFSET     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] loop_request;
    } t_in_item;

    typedef struct packed {
        logic signed [12:0] position;
        logic signed [15:0] loops_remaining;
        logic               moving_right;
        logic               redraw;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        scroll_mode;
        logic [7:0]        frames_per_step;
        logic [11:0]       text_width;
        logic [7:0]        visible_width;
        logic signed [8:0] left_offset;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] cur_position;
        logic signed [POS_W-1:0] pos_min;
        logic signed [POS_W-1:0] pos_max;
        logic signed [15:0]      loop_count;
        logic [8:0]              frame_count;
        t_mode                   active_mode;
    } t_state;

endpackage

[design/text_scroll_position_controller.sv]
// top level of the text scroll position controller
//
//   channel   direction  handshake                 payload
//   command   in         i_in_valid / o_in_ready   i_in_data  (cmd, loop_request)
//   result    out        o_out_valid / i_out_ready o_out_data (position, loops, flags)
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one command per cycle while the result is not stalled; each result passes through the
// command register and then the result register; the command register feeds the step logic,
// which updates the scroll state and the result register in the same edge
// a stalled result holds the pipe; the command register still takes a new
// transfer whenever it empties into the result register
// reset clears the scroll state and both valid flags, and sets the config registers to their defaults
`timescale 1ns / 1ps

module text_scroll_position_controller import tsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "text_scroll_position_controller_assert.svh"

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_state    r_st;
    t_state    n_st;
    t_out_item n_out;
    logic      out_load;
    logic      cmd_adv;

    tsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tsp_step u_step (
        .i_cfg  (cfg),
        .i_item (r_in),
        .i_st   (r_st),
        .o_st   (n_st),
        .o_out  (n_out)
    );

    assign out_load   = !r_out_valid || i_out_ready;
    assign cmd_adv    = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (cmd_adv) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (cmd_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TSP_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, cmd_adv, r_out_valid)
    `TSP_ASSERT_NEXT(a_no_redraw_off_tick, i_clk, i_rst_n,
        cmd_adv && r_in.cmd != CMD_TICK, !r_out.redraw)
    `TSP_ASSERT_NEXT(a_stop_one_loop, i_clk, i_rst_n,
        cmd_adv && r_in.cmd == CMD_STOP, r_out.loops_remaining == 16'sd1)
    `TSP_ASSERT_NEXT(a_redraw_clears_div, i_clk, i_rst_n,
        cmd_adv && n_out.redraw, r_st.frame_count == 9'd0)

endmodule

[design/tsp_cfg_regs.sv]
// configuration register file of the scroll position controller
`timescale 1ns / 1ps

module tsp_cfg_regs import tsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scroll_mode     <= 3'd0;
            r_cfg.frames_per_step <= 8'd0;
            r_cfg.text_width      <= 12'd0;
            r_cfg.visible_width   <= 8'd32;
            r_cfg.left_offset     <= 9'sd0;
        end else if (i_cfg_we) begin
            // indexes past the last register are dropped
            case (i_cfg_idx)
                REG_SCROLL_MODE:     r_cfg.scroll_mode     <= i_cfg_data[2:0];
                REG_FRAMES_PER_STEP: r_cfg.frames_per_step <= i_cfg_data[7:0];
                REG_TEXT_WIDTH:      r_cfg.text_width      <= i_cfg_data[11:0];
                REG_VISIBLE_WIDTH:   r_cfg.visible_width   <= i_cfg_data[7:0];
                REG_LEFT_OFFSET:     r_cfg.left_offset     <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/tsp_step.sv]
// next-state and result logic for one command of the scroll controller
`timescale 1ns / 1ps

module tsp_step import tsp_pkg::*; (
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    input  t_state    i_st,
    output t_state    o_st,
    output t_out_item o_out
);

    t_state                  n_st;
    t_mode                   start_mode;
    logic                    stepped;
    logic [8:0]              fc_inc;
    logic signed [POS_W-1:0] pos_dec;
    logic signed [POS_W-1:0] pos_inc;
    logic signed [15:0]      loops_dec;
    logic signed [POS_W-1:0] offset_ext;
    logic signed [POS_W-1:0] min_start;
    logic signed [POS_W-1:0] max_start;

    always_comb begin
        // codes above bounce reverse behave exactly like off
        if (i_cfg.scroll_mode > 3'(MODE_BOUNCE_REV)) begin
            start_mode = MODE_OFF;
        end else begin
            start_mode = t_mode'(i_cfg.scroll_mode);
        end
    end

    assign pos_dec    = i_st.cur_position - POS_W'(1);
    assign pos_inc    = i_st.cur_position + POS_W'(1);
    assign loops_dec  = (i_st.loop_count > 0) ? (i_st.loop_count - 16'sd1) : i_st.loop_count;
    assign offset_ext = POS_W'(i_cfg.left_offset);
    assign min_start  = POS_W'(0) - POS_W'({1'b0, i_cfg.text_width});
    assign max_start  = POS_W'({1'b0, i_cfg.visible_width});
    assign fc_inc     = i_st.frame_count + 9'd1;

    always_comb begin
        n_st    = i_st;
        stepped = 1'b0;
        unique case (i_item.cmd)
            CMD_START: begin
                n_st.loop_count  = i_item.loop_request;
                n_st.active_mode = start_mode;
                unique case (start_mode)
                    MODE_WRAP, MODE_BOUNCE_FWD: begin
                        n_st.pos_min      = min_start;
                        n_st.pos_max      = max_start;
                        n_st.cur_position = max_start;
                    end
                    MODE_WRAP_LEFT: begin
                        n_st.pos_min      = min_start;
                        n_st.pos_max      = max_start;
                        n_st.cur_position = offset_ext;
                    end
                    MODE_BOUNCE_REV: begin
                        n_st.pos_min      = min_start;
                        n_st.pos_max      = max_start;
                        n_st.cur_position = min_start;
                    end
                    default: begin
                        n_st.pos_min      = '0;
                        n_st.pos_max      = '0;
                        n_st.cur_position = '0;
                    end
                endcase
            end
            CMD_STOP: begin
                n_st.loop_count   = 16'sd1;
                n_st.cur_position = i_st.pos_min;
            end
            CMD_TICK: begin
                // idle ticks leave the frame divider alone
                if (i_st.loop_count != 16'sd0) begin
                    n_st.frame_count = fc_inc;
                    if (fc_inc > {1'b0, i_cfg.frames_per_step}) begin
                        n_st.frame_count = 9'd0;
                        stepped          = 1'b1;
                        unique case (i_st.active_mode)
                            MODE_WRAP, MODE_WRAP_LEFT: begin
                                if (pos_dec <= i_st.pos_min) begin
                                    n_st.cur_position = i_st.pos_max;
                                    n_st.loop_count   = loops_dec;
                                end else begin
                                    n_st.cur_position = pos_dec;
                                end
                            end
                            MODE_BOUNCE_FWD: begin
                                n_st.cur_position = pos_dec;
                                if (pos_dec <= i_st.pos_min) begin
                                    n_st.active_mode = MODE_BOUNCE_REV;
                                    n_st.loop_count  = loops_dec;
                                end
                            end
                            MODE_BOUNCE_REV: begin
                                n_st.cur_position = pos_inc;
                                if (pos_inc >= i_st.pos_max) begin
                                    n_st.active_mode = MODE_BOUNCE_FWD;
                                    n_st.loop_count  = loops_dec;
                                end
                            end
                            default: begin
                                n_st.cur_position = offset_ext;
                            end
                        endcase
                    end
                end
            end
            CMD_NOP: begin
            end
        endcase
    end

    assign o_st                  = n_st;
    assign o_out.position        = n_st.cur_position[12:0];
    assign o_out.loops_remaining = n_st.loop_count;
    assign o_out.moving_right    = (n_st.active_mode == MODE_BOUNCE_REV);
    assign o_out.redraw          = stepped;

endmodule
